FILE: hdl/sblm_pkg.sv
// ----------------------------------------------------------------------------
// sblm_pkg
// Shared types and constants for the serial loaded bank mapper.
// ----------------------------------------------------------------------------
package sblm_pkg;

	localparam int MAX_PRG_BANKS = 16;

	localparam logic [1:0] REQ_CPU_READ  = 2'd0;
	localparam logic [1:0] REQ_CPU_WRITE = 2'd1;
	localparam logic [1:0] REQ_PPU_READ  = 2'd2;
	localparam logic [1:0] REQ_PPU_WRITE = 2'd3;

	localparam logic [1:0] TGT_NONE    = 2'd0;
	localparam logic [1:0] TGT_PRG_RAM = 2'd1;
	localparam logic [1:0] TGT_PRG_ROM = 2'd2;
	localparam logic [1:0] TGT_CHR     = 2'd3;

	localparam logic [1:0] CFG_PRG_COUNT   = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT   = 2'd1;
	localparam logic [1:0] CFG_BOOT_MIRROR = 2'd2;

	localparam logic [1:0] SEL_CONTROL  = 2'd0;
	localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
	localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
	localparam logic [1:0] SEL_PRG      = 2'd3;

	localparam logic [4:0]  SERIAL_EMPTY  = 5'h10;
	localparam logic [4:0]  CONTROL_BOOT  = 5'h0C;
	localparam logic [1:0]  MIRROR_VERT   = 2'd2;
	localparam logic [1:0]  MIRROR_HORIZ  = 2'd3;
	localparam logic [15:0] ADDR_CLAIM    = 16'h4020;
	localparam logic [15:0] ADDR_PRG_RAM  = 16'h6000;
	localparam logic [15:0] ADDR_PRG_ROM  = 16'h8000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] bus_address;
		logic [7:0]  bus_data;
	} sblm_in_t;

	typedef struct packed {
		logic        claimed;
		logic [1:0]  target;
		logic [17:0] mem_address;
		logic        write_enable;
		logic [7:0]  write_byte;
		logic [1:0]  mirror_mode;
	} sblm_out_t;

	// Translation result of one access, before the mirror mode is attached.
	typedef struct packed {
		logic        claimed;
		logic [1:0]  target;
		logic [17:0] mem_address;
		logic        write_enable;
		logic [7:0]  write_byte;
	} sblm_map_t;

	// Bank registers as seen by the address translation.
	typedef struct packed {
		logic [4:0] control_word;
		logic [4:0] chr_low_bank;
		logic [4:0] chr_high_bank;
		logic [4:0] prg_bank;
		logic [4:0] prg_count;
	} sblm_banks_t;

	function automatic logic [4:0] clamp_count(input logic [4:0] c);
		logic [4:0] r;
		r = c;
		if (c == 5'd0) begin
			r = 5'd1;
		end else if (c > 5'(MAX_PRG_BANKS)) begin
			r = 5'(MAX_PRG_BANKS);
		end
		return r;
	endfunction

endpackage

FILE: hdl/sblm_mod_unit.sv
// ----------------------------------------------------------------------------
// sblm_mod_unit
// Restoring remainder unit: one dividend bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module sblm_mod_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [4:0] dividend,
	input  logic [5:0] divisor,
	output logic       done,
	output logic [4:0] remainder
);
	import sblm_pkg::*;

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [4:0] dvd_q;
	logic [5:0] dsr_q;
	logic [5:0] rem_q;
	logic [5:0] trial;

	// Shift in the next dividend bit and subtract when the divisor fits.
	always_comb begin
		trial = {rem_q[4:0], dvd_q[4]};
		if (trial >= dsr_q) begin
			trial = trial - dsr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd5;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 3'd1;
				if (cnt_q == 3'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= 6'd0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[3:0], 1'b0};
			rem_q <= trial;
		end
	end

	assign done      = done_q;
	assign remainder = rem_q[4:0];

endmodule

FILE: hdl/sblm_addr_map.sv
// ----------------------------------------------------------------------------
// sblm_addr_map
// Translates one CPU or PPU access into a memory target and physical address.
// ----------------------------------------------------------------------------
module sblm_addr_map (
	input  sblm_pkg::sblm_in_t    item,
	input  sblm_pkg::sblm_banks_t banks,
	output sblm_pkg::sblm_map_t   map
);
	import sblm_pkg::*;

	logic [1:0]  prg_mode;
	logic [3:0]  prg_sel;
	logic [4:0]  chr_sel;
	logic [12:0] ppu_addr;
	logic        is_write;

	always_comb begin
		prg_mode = banks.control_word[3:2];
		ppu_addr = item.bus_address[12:0];
		is_write = (item.req_type == REQ_CPU_WRITE) || (item.req_type == REQ_PPU_WRITE);
		prg_sel  = 4'd0;
		chr_sel  = 5'd0;
		map      = '0;
		if ((item.req_type == REQ_CPU_READ) || (item.req_type == REQ_CPU_WRITE)) begin
			map.claimed = (item.bus_address >= ADDR_CLAIM);
			if ((item.bus_address >= ADDR_PRG_RAM) && (item.bus_address < ADDR_PRG_ROM)) begin
				if (!banks.prg_bank[4]) begin
					map.target       = TGT_PRG_RAM;
					map.mem_address  = {5'd0, item.bus_address[12:0]};
					map.write_enable = is_write;
				end
			end else if (item.bus_address >= ADDR_PRG_ROM && !is_write) begin
				map.target = TGT_PRG_ROM;
				if (!prg_mode[1]) begin
					// 32KB mode ignores the low bank bit.
					map.mem_address = {banks.prg_bank[3:1], item.bus_address[14:0]};
				end else begin
					if (prg_mode[0]) begin
						// Last bank fixed at the upper window.
						prg_sel = item.bus_address[14] ? 4'(banks.prg_count - 5'd1)
						                               : banks.prg_bank[3:0];
					end else begin
						// First bank fixed at the lower window.
						prg_sel = item.bus_address[14] ? banks.prg_bank[3:0] : 4'd0;
					end
					map.mem_address = {prg_sel, item.bus_address[13:0]};
				end
			end
		end else begin
			map.claimed      = 1'b1;
			map.target       = TGT_CHR;
			map.write_enable = is_write;
			if (banks.control_word[4]) begin
				chr_sel = ppu_addr[12] ? banks.chr_high_bank : banks.chr_low_bank;
				map.mem_address = {1'b0, chr_sel, ppu_addr[11:0]};
			end else begin
				map.mem_address = {1'b0, banks.chr_low_bank[4:1], ppu_addr};
			end
		end
		map.write_byte = map.write_enable ? item.bus_data : 8'd0;
	end

endmodule

FILE: hdl/serial_loaded_bank_mapper.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Serially loaded cartridge bank mapper for CPU and PPU bus accesses.
// ----------------------------------------------------------------------------
// Each accepted item is one bus access and yields exactly one result item with
// the memory target, the physical byte address, a write strobe with its byte,
// and the nametable mirror mode after the access. An item is registered, then
// translated and applied in the next cycle, and its result is loaded into the
// output register at the end of that cycle; it leaves when out_stall is low. A
// serial write that completes a CHR or PRG bank value then runs the shared
// remainder unit for five steps and writes the reduced value back in ST_DIV
// once the unit is done. The input stalls until such an item is through, and
// for any other item until it has been translated and applied. The next item
// may be accepted while a result still waits in the output register only once
// that result leaves at the same edge. Configuration writes on the cfg port
// are meant for idle periods; writing the boot mirror register also reloads
// the mirror bits of the control register at once.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sblm_pkg::sblm_in_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output sblm_pkg::sblm_out_t out_item,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [4:0]          cfg_data
);
	import sblm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_EXEC = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t      state_q;
	sblm_in_t    item_q;
	sblm_out_t   out_q;
	logic        out_valid_q;

	// Configuration registers.
	logic [4:0]  prg_count_q;
	logic [4:0]  chr_count_q;

	// Mapper state.
	logic [4:0]  serial_q;
	logic [4:0]  control_q;
	logic [4:0]  chr_low_q;
	logic [4:0]  chr_high_q;
	logic [4:0]  prg_bank_q;

	// Pending bank commit while the remainder unit runs.
	logic [1:0]  pend_sel_q;
	logic        pend_bit4_q;

	sblm_banks_t banks;
	sblm_map_t   map;
	logic        accept;
	logic        serial_write;
	logic [4:0]  shifted;
	logic        commit;
	logic [1:0]  sel;
	logic [4:0]  prg_clamped;
	logic [4:0]  control_next;
	logic        mod_start;
	logic [4:0]  mod_dividend;
	logic [5:0]  mod_divisor;
	logic        mod_done;
	logic [4:0]  mod_rem;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);

	assign prg_clamped = clamp_count(prg_count_q);

	always_comb begin
		banks.control_word  = control_q;
		banks.chr_low_bank  = chr_low_q;
		banks.chr_high_bank = chr_high_q;
		banks.prg_bank      = prg_bank_q;
		banks.prg_count     = prg_clamped;
	end

	sblm_addr_map u_map (
		.item  (item_q),
		.banks (banks),
		.map   (map)
	);

	// Serial port decode: a CPU write in the ROM window feeds the shift
	// register, LSB first. The fifth bit is there when the marker reaches bit 0.
	always_comb begin
		serial_write = (item_q.req_type == REQ_CPU_WRITE) &&
		               (item_q.bus_address >= ADDR_PRG_ROM);
		shifted      = {item_q.bus_data[0], serial_q[4:1]};
		commit       = serial_write && !item_q.bus_data[7] && serial_q[0];
		sel          = item_q.bus_address[14:13];
		control_next = control_q;
		if (serial_write && item_q.bus_data[7]) begin
			control_next = control_q | CONTROL_BOOT;
		end else if (commit && (sel == SEL_CONTROL)) begin
			control_next = shifted;
		end
		mod_start    = (state_q == ST_EXEC) && commit && (sel != SEL_CONTROL);
		mod_dividend = (sel == SEL_PRG) ? {1'b0, shifted[3:0]} : shifted;
		mod_divisor  = (sel == SEL_PRG) ? {1'b0, prg_clamped}
		                                : {clamp_count(chr_count_q), 1'b0};
	end

	sblm_mod_unit u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (mod_dividend),
		.divisor   (mod_divisor),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			prg_count_q <= 5'd2;
			chr_count_q <= 5'd1;
			serial_q    <= SERIAL_EMPTY;
			control_q   <= CONTROL_BOOT | {3'd0, MIRROR_HORIZ};
			chr_low_q   <= 5'd0;
			chr_high_q  <= 5'd0;
			prg_bank_q  <= 5'd0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					out_valid_q <= 1'b1;
					control_q   <= control_next;
					if (serial_write) begin
						if (item_q.bus_data[7] || serial_q[0]) begin
							serial_q <= SERIAL_EMPTY;
						end else begin
							serial_q <= shifted;
						end
					end
					state_q <= mod_start ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					if (mod_done) begin
						case (pend_sel_q)
							SEL_CHR_LOW:  chr_low_q  <= mod_rem;
							SEL_CHR_HIGH: chr_high_q <= mod_rem;
							default:      prg_bank_q <= {pend_bit4_q, mod_rem[3:0]};
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					CFG_PRG_COUNT: prg_count_q <= cfg_data;
					CFG_CHR_COUNT: chr_count_q <= cfg_data;
					CFG_BOOT_MIRROR: begin
						control_q   <= {control_q[4:2],
						                cfg_data[0] ? MIRROR_VERT : MIRROR_HORIZ};
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_item;
		end
		if (state_q == ST_EXEC) begin
			out_q.claimed      <= map.claimed;
			out_q.target       <= map.target;
			out_q.mem_address  <= map.mem_address;
			out_q.write_enable <= map.write_enable;
			out_q.write_byte   <= map.write_byte;
			out_q.mirror_mode  <= control_next[1:0];
			pend_sel_q         <= sel;
			pend_bit4_q        <= shifted[4];
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: sim/serial_loaded_bank_mapper_tb.sv
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_tb
// Self-checking bench for the serial loaded bank mapper.
// ----------------------------------------------------------------------------
// Bus accesses are sent through the input channel while a cycle-free model of
// the mapper, kept inside this bench, works out the result of every accepted
// item. Results are compared field by field, in order, as they leave the block.
// A short directed part covers the decode boundaries, every request type, the
// serial reset and the register commits; the bulk is random traffic built
// mostly from complete five-write register loads, with broken loads and noise
// mixed in, run under several bank count and mirror settings.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper_tb;
	import sblm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int RANDOM_ITEMS  = 1400;
	localparam int SETTING_COUNT = 8;

	// PRG banking modes held in control bits 3:2.
	localparam logic [1:0] PRG_SWITCH_32K_A  = 2'd0;
	localparam logic [1:0] PRG_SWITCH_32K_B  = 2'd1;
	localparam logic [1:0] PRG_FIX_FIRST     = 2'd2;
	localparam logic [1:0] PRG_FIX_LAST      = 2'd3;
	localparam logic [15:0] ADDR_UPPER_16K   = 16'hC000;
	localparam logic [7:0]  DATA_SERIAL_RESET = 8'h80;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	sblm_in_t   in_item = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	sblm_out_t  out_item;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = CFG_PRG_COUNT;
	logic [4:0] cfg_data = '0;

	// Shadow copy of the mapper's configuration and bank registers.
	logic [4:0] m_prg_count;
	logic [4:0] m_chr_count;
	logic       m_boot_vertical;
	logic [4:0] m_serial;
	logic [4:0] m_control;
	logic [4:0] m_chr_low;
	logic [4:0] m_chr_high;
	logic [4:0] m_prg;

	// Translations still owed by the block, oldest first.
	sblm_out_t pending_results[$];

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int burst_left = 0;
	bit gaps_enabled = 1'b1;
	int stall_mode = 0;
	int stall_span = 0;
	int stall_tick = 0;

	serial_loaded_bank_mapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// The result side stalls in spans of random length, each span with its own
	// character: never, rarely, mostly, or in regular repeating blocks.
	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_span <= $urandom_range(20, 150);
		end else begin
			stall_span <= stall_span - 1;
		end
		stall_tick <= stall_tick + 1;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((stall_tick % 12) < 7);
		endcase
	end

	task automatic check_field(input string name, input logic [17:0] want,
			input logic [17:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			errors++;
		end
	endtask

	// Every result taken by the receiver is matched against the oldest
	// translation still owed.
	always @(posedge clk) begin : result_check
		sblm_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result item arrived with nothing pending: %p", out_item);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("claimed", 18'(want.claimed), 18'(out_item.claimed));
				check_field("target", 18'(want.target), 18'(out_item.target));
				check_field("mem_address", want.mem_address, out_item.mem_address);
				check_field("write_enable", 18'(want.write_enable),
					18'(out_item.write_enable));
				check_field("write_byte", 18'(want.write_byte),
					18'(out_item.write_byte));
				check_field("mirror_mode", 18'(want.mirror_mode),
					18'(out_item.mirror_mode));
			end
		end
	end

	// Bank counts outside 1..16 are treated as the nearest legal count.
	function automatic logic [4:0] fitted_banks(input logic [4:0] c);
		if (c == 5'd0) begin
			return 5'd1;
		end
		if (c > 5'(MAX_PRG_BANKS)) begin
			return 5'(MAX_PRG_BANKS);
		end
		return c;
	endfunction

	task automatic restore_power_on();
		m_prg_count = 5'd2;
		m_chr_count = 5'd1;
		m_boot_vertical = 1'b0;
		m_serial = SERIAL_EMPTY;
		m_control = CONTROL_BOOT | 5'(MIRROR_HORIZ);
		m_chr_low = '0;
		m_chr_high = '0;
		m_prg = '0;
	endtask

	// One CPU write into the serial port at 0x8000 and above. Bit 7 clears the
	// shift register and forces 16KB mode with the last bank fixed; otherwise
	// bit 0 shifts in from the top, and the fifth bit commits the value to the
	// register picked by address bits 14:13.
	function automatic void shift_in(input logic [15:0] addr, input logic [7:0] data);
		logic       complete;
		logic [4:0] v;
		int         prg_div;
		int         chr_div;
		if (data[7]) begin
			m_serial = SERIAL_EMPTY;
			m_control = m_control | CONTROL_BOOT;
			return;
		end
		complete = m_serial[0];
		m_serial = {data[0], m_serial[4:1]};
		if (!complete) begin
			return;
		end
		v = m_serial;
		prg_div = int'(fitted_banks(m_prg_count));
		chr_div = 2 * int'(fitted_banks(m_chr_count));
		case (addr[14:13])
			SEL_CONTROL:  m_control = v;
			SEL_CHR_LOW:  m_chr_low = 5'(int'(v) % chr_div);
			SEL_CHR_HIGH: m_chr_high = 5'(int'(v) % chr_div);
			SEL_PRG:      m_prg = {v[4], 4'(int'(v[3:0]) % prg_div)};
		endcase
		m_serial = SERIAL_EMPTY;
	endfunction

	// Translates one access against the shadow registers and applies any
	// register load it carries. The mirror mode reported is the one after it.
	function automatic sblm_out_t map_access(input sblm_in_t it);
		sblm_out_t   r;
		logic [15:0] a;
		logic [12:0] pa;
		logic [4:0]  bank;
		logic        is_write;
		r = '0;
		a = it.bus_address;
		r.claimed = 1'b1;
		if (it.req_type == REQ_CPU_READ || it.req_type == REQ_CPU_WRITE) begin
			is_write = (it.req_type == REQ_CPU_WRITE);
			r.claimed = (a >= ADDR_CLAIM);
			if (a >= ADDR_PRG_RAM && a < ADDR_PRG_ROM) begin
				// Bank bit 4 switches the work RAM off.
				if (!m_prg[4]) begin
					r.target = TGT_PRG_RAM;
					r.mem_address = 18'(a[12:0]);
					r.write_enable = is_write;
				end
			end else if (a >= ADDR_PRG_ROM) begin
				if (is_write) begin
					shift_in(a, it.bus_data);
				end else begin
					r.target = TGT_PRG_ROM;
					case (m_control[3:2])
						PRG_SWITCH_32K_A, PRG_SWITCH_32K_B: begin
							r.mem_address = {m_prg[3:1], a[14:0]};
						end
						PRG_FIX_FIRST: begin
							bank = (a < ADDR_UPPER_16K) ? 5'd0 : {1'b0, m_prg[3:0]};
							r.mem_address = {bank[3:0], a[13:0]};
						end
						PRG_FIX_LAST: begin
							bank = (a >= ADDR_UPPER_16K) ? fitted_banks(m_prg_count) - 5'd1
								: {1'b0, m_prg[3:0]};
							r.mem_address = {bank[3:0], a[13:0]};
						end
					endcase
				end
			end
		end else begin
			pa = a[12:0];
			r.target = TGT_CHR;
			if (m_control[4]) begin
				bank = pa[12] ? m_chr_high : m_chr_low;
				r.mem_address = 18'({bank, pa[11:0]});
			end else begin
				r.mem_address = 18'({m_chr_low[4:1], pa});
			end
			r.write_enable = (it.req_type == REQ_PPU_WRITE);
		end
		r.write_byte = r.write_enable ? it.bus_data : 8'h00;
		r.mirror_mode = m_control[1:0];
		return r;
	endfunction

	// Sends one item. At the end of a burst the valid line may drop for a
	// random gap; that drop happens at the step where the previous item was
	// taken, so valid is never lowered and raised in the same step.
	task automatic send_item(input logic [1:0] req, input logic [15:0] addr,
			input logic [7:0] data);
		sblm_in_t it;
		int       gap;
		it.req_type = req;
		it.bus_address = addr;
		it.bus_data = data;
		if (gaps_enabled && burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else if (burst_left > 0) begin
			burst_left--;
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(map_access(it));
		items_sent++;
	endtask

	// Drops valid, then waits until every owed result has come back and the
	// block has had time to finish any bank reduction still in flight.
	task automatic settle();
		if (in_valid) begin
			in_valid <= 1'b0;
		end
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CFG_PRG_COUNT: m_prg_count = val;
			CFG_CHR_COUNT: m_chr_count = val;
			CFG_BOOT_MIRROR: begin
				// The mirror bits of control follow this register at once.
				m_boot_vertical = val[0];
				m_control = {m_control[4:2], val[0] ? MIRROR_VERT : MIRROR_HORIZ};
			end
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [4:0] prg_count, input logic [4:0] chr_count,
			input logic [4:0] mirror);
		settle();
		write_cfg(CFG_PRG_COUNT, prg_count);
		write_cfg(CFG_CHR_COUNT, chr_count);
		write_cfg(CFG_BOOT_MIRROR, mirror);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// A full five-write load of one register, LSB first. If the shift register
	// is not empty, or now and then anyway, a reset write goes first.
	task automatic load_register(input logic [1:0] sel, input logic [4:0] value);
		logic [15:0] addr;
		if (m_serial != SERIAL_EMPTY || $urandom_range(0, 3) == 0) begin
			send_item(REQ_CPU_WRITE, ADDR_PRG_ROM | 16'($urandom),
				DATA_SERIAL_RESET | 8'($urandom));
		end
		for (int i = 0; i < 5; i++) begin
			addr = ADDR_PRG_ROM | 16'($urandom);
			if (i == 4) begin
				addr[14:13] = sel;
			end
			send_item(REQ_CPU_WRITE, addr, {1'b0, 6'($urandom), value[i]});
		end
	endtask

	// Any request type at an address biased toward the interesting windows.
	task automatic send_noise();
		logic [1:0]  req;
		logic [15:0] addr;
		req = 2'($urandom_range(0, 3));
		case ($urandom_range(0, 4))
			0: addr = 16'($urandom);
			1: addr = 16'($urandom_range(16'h6000, 16'h7FFF));
			2: addr = 16'($urandom_range(16'h8000, 16'hFFFF));
			3: addr = 16'($urandom_range(16'h4000, 16'h403F));
			default: addr = 16'($urandom_range(0, 16'h1FFF));
		endcase
		send_item(req, addr, 8'($urandom));
	endtask

	// Claim and target boundaries, all four request types, PPU address bits
	// above bit 12 and the fixed-last-bank mode that reset leaves in place.
	task automatic test_decode_extremes();
		send_item(REQ_CPU_READ, 16'h0000, 8'hFF);
		send_item(REQ_CPU_READ, 16'h401F, 8'h00);
		send_item(REQ_CPU_READ, ADDR_CLAIM, 8'h00);
		send_item(REQ_CPU_READ, 16'h5FFF, 8'h00);
		send_item(REQ_CPU_WRITE, ADDR_CLAIM, 8'hFF);
		send_item(REQ_CPU_READ, ADDR_PRG_RAM, 8'h00);
		send_item(REQ_CPU_WRITE, 16'h7FFF, 8'hFF);
		send_item(REQ_CPU_READ, ADDR_PRG_ROM, 8'h00);
		send_item(REQ_CPU_READ, 16'hBFFF, 8'h00);
		send_item(REQ_CPU_READ, ADDR_UPPER_16K, 8'h00);
		send_item(REQ_CPU_READ, 16'hFFFF, 8'h00);
		send_item(REQ_PPU_READ, 16'h0000, 8'h00);
		send_item(REQ_PPU_READ, 16'h1FFF, 8'hFF);
		send_item(REQ_PPU_WRITE, 16'hFFFF, 8'hA5);
		send_item(REQ_PPU_WRITE, 16'h1000, 8'h00);
	endtask

	// The serial port itself: a reset write, a PRG commit that disables the
	// work RAM and needs the bank count reduction, RAM accesses while it is
	// off, and a load broken off by a reset write halfway.
	task automatic test_serial_commits();
		send_item(REQ_CPU_WRITE, 16'hFFFF, DATA_SERIAL_RESET);
		load_register(SEL_PRG, 5'b1_0011);
		send_item(REQ_CPU_READ, ADDR_PRG_RAM, 8'h00);
		send_item(REQ_CPU_WRITE, 16'h7000, 8'h5A);
		send_item(REQ_CPU_WRITE, ADDR_PRG_ROM, 8'h01);
		send_item(REQ_CPU_WRITE, 16'hE000, 8'h00);
		send_item(REQ_CPU_WRITE, 16'hA000, 8'hFE);
		load_register(SEL_PRG, 5'b0_0000);
		send_item(REQ_CPU_READ, ADDR_PRG_RAM, 8'h00);
	endtask

	// Random traffic: mostly complete register loads, each followed by a few
	// accesses of any request type, then broken loads and plain noise.
	task automatic test_random_traffic(input int count);
		int stop_at;
		int partial;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: begin
					load_register(2'($urandom), 5'($urandom));
					repeat ($urandom_range(1, 4)) send_noise();
				end
				5: begin
					partial = $urandom_range(1, 4);
					repeat (partial) begin
						send_item(REQ_CPU_WRITE, ADDR_PRG_ROM | 16'($urandom),
							8'($urandom) & 8'h7F);
					end
					send_item(REQ_CPU_WRITE, ADDR_PRG_ROM | 16'($urandom),
						DATA_SERIAL_RESET | 8'($urandom));
				end
				default: send_noise();
			endcase
		end
	endtask

	// Bank counts at the legal extremes, out of range on both sides, the reset
	// values and random picks, each with random traffic. One setting in three
	// runs the sender without gaps.
	task automatic test_bank_count_settings();
		logic [4:0] prg_pick[5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd2};
		logic [4:0] chr_pick[5] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd1};
		logic [4:0] prg_count;
		logic [4:0] chr_count;
		for (int s = 0; s < SETTING_COUNT; s++) begin
			if (s < 5) begin
				prg_count = prg_pick[s];
				chr_count = chr_pick[s];
			end else begin
				prg_count = 5'($urandom);
				chr_count = 5'($urandom);
			end
			apply_settings(prg_count, chr_count, 5'($urandom));
			gaps_enabled = (s % 3 != 2);
			test_random_traffic(RANDOM_ITEMS / SETTING_COUNT);
		end
		gaps_enabled = 1'b1;
	endtask

	initial begin
		restore_power_on();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decode_extremes();
		test_serial_commits();
		test_bank_count_settings();
		settle();
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/sblm_pkg.sv
hdl/sblm_mod_unit.sv
hdl/sblm_addr_map.sv
hdl/serial_loaded_bank_mapper.sv
sim/serial_loaded_bank_mapper_tb.sv
